### hdl/assert_macros.svh
// Assertion helpers. Define NO_ASSERTIONS to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

### hdl/ple_pkg.sv
`default_nettype none

package ple_pkg;

  localparam int DEPTH     = 16;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int POS_W     = 5;
  localparam int OUT_POS_W = 5;
  localparam int OUT_CNT_W = 5;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Function codes; code 7 is unused and answers with a range error.
  localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_START = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_END   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_AT    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_START = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_END   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SHOW      = 3'd6;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic {
    CS_IDLE,
    CS_SHOW
  } ctrl_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic [OUT_POS_W-1:0]     entry_position;
    logic signed [DATA_W-1:0] entry_data;
    logic [OUT_CNT_W-1:0]     entry_count;
    logic                     last;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic op_exec;     // execute the input item, load its single result
    logic show_start;  // take show item, rewind the show pointer
    logic show_emit;   // load one listed entry into the output register
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic slot_free;   // output register empty or being taken this cycle
    logic is_show;     // input item is a show
    logic cnt_zero;    // list empty
    logic show_last;   // show pointer at final entry
  } dp_sts_t;

endpackage

`default_nettype wire

### hdl/positional_list_engine.sv
`default_nettype none
`include "assert_macros.svh"

// Bounded positional list: holds up to ple_pkg::DEPTH signed 32-bit words,
// numbered from 1, in a register shift chain. Each input transfer is one
// operation (insert at/start/end, delete at/start/end, show). Insert and
// delete shift the whole chain in parallel and answer with one result
// carrying status and the new count, so they run at one item per cycle as
// long as the output side takes each result. Show first rewinds its
// pointer, then lists the entries one per cycle through the output
// register while the output side does not stall; an empty list answers
// with a single result carrying an empty status. The single output
// register sets the pace: a new item is taken while the previous result
// waits only if that result is taken in the same cycle. A range error is
// checked before the full check; func code 7 answers with a range error.
module positional_list_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // operation channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ple_pkg::in_item_t  in_data_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ple_pkg::out_item_t      out_data_o
);
  import ple_pkg::*;

  ctrl_cmd_t cmd;   // controller commands
  dp_sts_t   sts;   // datapath status

  // controller: idle / show sequencing and input flow control
  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: shift chain, count, show pointer, output register
  ple_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // every accepted transfer starts exactly one kind of work
  `ASSERT_AT(a_accept_cmd, clk_i, rst_ni, (in_valid_i && !in_stall_o) |-> (cmd.op_exec != cmd.show_start), "accept without command")

endmodule

`default_nettype wire

### hdl/ple_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module ple_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ple_pkg::dp_sts_t   sts_i,
  output ple_pkg::ctrl_cmd_t      cmd_o
);
  import ple_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      CS_IDLE: begin
        in_stall_o = !sts_i.slot_free;
        if (in_valid_i && sts_i.slot_free) begin
          if (sts_i.is_show && !sts_i.cnt_zero) begin
            cmd_o.show_start = 1'b1;
            state_d          = CS_SHOW;
          end else begin
            cmd_o.op_exec = 1'b1;
          end
        end
      end
      CS_SHOW: begin
        if (sts_i.slot_free) begin
          cmd_o.show_emit = 1'b1;
          if (sts_i.show_last) begin
            state_d = CS_IDLE;
          end
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  // a listing only runs over a non-empty list
  `ASSERT_NEVER(a_show_nonempty, clk_i, rst_ni, (state_q == CS_SHOW) && sts_i.cnt_zero, "show on empty list")
  // no new transfer is taken while a listing is running
  `ASSERT_AT(a_show_blocks, clk_i, rst_ni, (state_q == CS_SHOW) |-> (cmd_o.op_exec == 1'b0) && (cmd_o.show_start == 1'b0), "item taken during show")

endmodule

`default_nettype wire

### hdl/ple_dpath.sv
`default_nettype none
`include "assert_macros.svh"

module ple_dpath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ple_pkg::in_item_t   in_data_i,
  input  wire logic                out_stall_i,
  input  wire ple_pkg::ctrl_cmd_t  cmd_i,
  output ple_pkg::dp_sts_t         sts_o,
  output logic                     out_valid_o,
  output ple_pkg::out_item_t       out_data_o
);
  import ple_pkg::*;

  logic signed [DATA_W-1:0] entries_q [DEPTH];
  logic signed [DATA_W-1:0] entries_d [DEPTH];
  logic [CNT_W-1:0]         count_q, count_d;
  logic [IDX_W-1:0]         show_idx_q;
  logic                     out_valid_q;
  out_item_t                out_q;

  status_e          op_status;
  logic             do_ins, do_del;
  logic [CMP_W-1:0] op_idx, pos_x, cnt_x;
  logic             list_full, list_empty;

  assign pos_x      = CMP_W'(in_data_i.position);
  assign cnt_x      = CMP_W'(count_q);
  assign list_full  = (count_q == CNT_W'(DEPTH));
  assign list_empty = (count_q == '0);

  // operation decode: status and shift point
  always_comb begin
    op_status = ST_OK;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    op_idx    = '0;
    unique case (in_data_i.func)
      FN_INS_AT: begin
        if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
          op_status = ST_RANGE;
        end else if (list_full) begin
          op_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          op_idx = pos_x - CMP_W'(1);
        end
      end
      FN_INS_START: begin
        if (list_full) begin
          op_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      FN_INS_END: begin
        if (list_full) begin
          op_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          op_idx = cnt_x;
        end
      end
      FN_DEL_AT: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          op_status = ST_RANGE;
        end else begin
          do_del = 1'b1;
          op_idx = pos_x - CMP_W'(1);
        end
      end
      FN_DEL_START: begin
        if (list_empty) begin
          op_status = ST_EMPTY;
        end else begin
          do_del = 1'b1;
        end
      end
      FN_DEL_END: begin
        if (list_empty) begin
          op_status = ST_EMPTY;
        end else begin
          do_del = 1'b1;
          op_idx = cnt_x - CMP_W'(1);
        end
      end
      FN_SHOW: begin
        // only an empty-list show gets here
        op_status = ST_EMPTY;
      end
      default: begin
        op_status = ST_RANGE;
      end
    endcase
  end

  // shift chain: each slot keeps its own value, takes the new word, or takes its left or right neighbor
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_d[i] = entries_q[i];
      if (do_ins) begin
        if (CMP_W'(i) == op_idx) begin
          entries_d[i] = in_data_i.value;
        end else if (i > 0 && CMP_W'(i) > op_idx) begin
          entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del) begin
        if (i < DEPTH - 1 && CMP_W'(i) >= op_idx) begin
          entries_d[i] = entries_q[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_del) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_exec) begin
      entries_q <= entries_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      show_idx_q <= '0;
    end else begin
      if (cmd_i.op_exec) begin
        count_q <= count_d;
      end
      if (cmd_i.show_start) begin
        show_idx_q <= '0;
      end else if (cmd_i.show_emit) begin
        show_idx_q <= show_idx_q + IDX_W'(1);
      end
    end
  end

  logic [CNT_W-1:0] show_pos;
  assign show_pos = CNT_W'(show_idx_q) + CNT_W'(1);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op_exec || cmd_i.show_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_exec) begin
      out_q.status         <= op_status;
      out_q.entry_position <= '0;
      out_q.entry_data     <= '0;
      out_q.entry_count    <= OUT_CNT_W'(count_d);
      out_q.last           <= 1'b1;
    end else if (cmd_i.show_emit) begin
      out_q.status         <= ST_OK;
      out_q.entry_position <= OUT_POS_W'(show_pos);
      out_q.entry_data     <= entries_q[show_idx_q];
      out_q.entry_count    <= OUT_CNT_W'(count_q);
      out_q.last           <= sts_o.show_last;
    end
  end

  assign sts_o.slot_free = !out_valid_q || !out_stall_i;
  assign sts_o.is_show   = (in_data_i.func == FN_SHOW);
  assign sts_o.cnt_zero  = list_empty;
  assign sts_o.show_last = (show_pos == count_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_W'(DEPTH), "count above depth")
  `ASSERT_AT(a_op_single, clk_i, rst_ni, cmd_i.op_exec |=> out_valid_q && out_q.last, "single result not loaded")
  `ASSERT_AT(a_count_hold, clk_i, rst_ni, !cmd_i.op_exec |=> $stable(count_q), "count moved without an op")

endmodule

`default_nettype wire

### sim/ple_checker.sv
`default_nettype none

// Watches both channels of the list engine, keeps its own copy of the list,
// and compares every result transfer against the oldest predicted result.
module ple_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire ple_pkg::in_item_t  in_data_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire ple_pkg::out_item_t out_data_i,
  output int                      err_cnt_o,
  output int                      pend_cnt_o,
  output int                      checked_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic signed [DATA_W-1:0] words [DEPTH];
  int                       word_cnt;
  out_item_t                want_q [$];
  int                       err_cnt;
  int                       checked_cnt;

  function automatic void queue_result(status_e st, int pos,
                                       logic signed [DATA_W-1:0] d, bit lst);
    out_item_t r;
    r.status         = st;
    r.entry_position = OUT_POS_W'(pos);
    r.entry_data     = d;
    r.entry_count    = OUT_CNT_W'(word_cnt);
    r.last           = lst;
    want_q.push_back(r);
  endfunction

  // Range is checked ahead of the full check.
  function automatic status_e insert_word(int idx, logic signed [DATA_W-1:0] d);
    if (idx > word_cnt) return ST_RANGE;
    if (word_cnt >= DEPTH) return ST_FULL;
    for (int i = word_cnt; i > idx; i--) words[i] = words[i-1];
    words[idx] = d;
    word_cnt++;
    return ST_OK;
  endfunction

  function automatic void remove_word(int idx);
    for (int i = idx; i + 1 < word_cnt; i++) words[i] = words[i+1];
    word_cnt--;
  endfunction

  function automatic void predict_op(in_item_t op);
    status_e st;
    int      pos;
    st  = ST_OK;
    pos = int'(op.position);
    case (op.func)
      FN_INS_AT:    st = (pos == 0) ? ST_RANGE : insert_word(pos - 1, op.value);
      FN_INS_START: st = insert_word(0, op.value);
      FN_INS_END:   st = insert_word(word_cnt, op.value);
      FN_DEL_AT: begin
        if (pos == 0 || pos > word_cnt) st = ST_RANGE;
        else remove_word(pos - 1);
      end
      FN_DEL_START: begin
        if (word_cnt == 0) st = ST_EMPTY;
        else remove_word(0);
      end
      FN_DEL_END: begin
        if (word_cnt == 0) st = ST_EMPTY;
        else remove_word(word_cnt - 1);
      end
      FN_SHOW: begin
        if (word_cnt == 0) begin
          queue_result(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < word_cnt; i++)
            queue_result(ST_OK, i + 1, words[i], (i + 1 == word_cnt));
        end
        return;
      end
      default: st = ST_RANGE;
    endcase
    queue_result(st, 0, '0, 1'b1);
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (want_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= REPORT_LIMIT)
        $display("%0t: unexpected result st=%0d pos=%0d data=%0d cnt=%0d last=%0d",
                 $time, got.status, got.entry_position, got.entry_data,
                 got.entry_count, got.last);
      return;
    end
    want = want_q.pop_front();
    checked_cnt++;
    if (got.status !== want.status || got.entry_position !== want.entry_position ||
        got.entry_data !== want.entry_data || got.entry_count !== want.entry_count ||
        got.last !== want.last) begin
      err_cnt++;
      if (err_cnt <= REPORT_LIMIT) begin
        $write("%0t: mismatch want st=%0d pos=%0d data=%0d cnt=%0d last=%0d,",
               $time, want.status, want.entry_position, want.entry_data,
               want.entry_count, want.last);
        $display(" got st=%0d pos=%0d data=%0d cnt=%0d last=%0d",
                 got.status, got.entry_position, got.entry_data,
                 got.entry_count, got.last);
      end
    end
  endfunction

  // Results leave before a same-edge operation can add any.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_cnt    = 0;
      err_cnt     = 0;
      checked_cnt = 0;
      want_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) predict_op(in_data_i);
    end
    err_cnt_o     <= err_cnt;
    pend_cnt_o    <= want_q.size();
    checked_cnt_o <= checked_cnt;
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

// Top of the list engine bench: makes reset, clock, operation stimulus and
// result-side stalls. All checking lives in ple_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;   // answers with a range error
  localparam int RANDOM_OPS  = 280;
  localparam int QUIET_TAIL  = 60;                    // last ops run with no idling
  localparam int DRAIN_WAIT  = 24;                    // longer than one full show
  localparam int CYCLE_LIMIT = 400000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      op_valid  = 1'b0;
  in_item_t  op_item   = '0;
  logic      res_stall = 1'b0;
  logic      in_stall;
  logic      res_valid;
  out_item_t res_item;

  int err_cnt, pend_cnt, checked_cnt;

  // Idle knobs, shared with the result-side stall process.
  int in_idle_pct  = 30;
  int out_idle_pct = 30;
  bit quiet        = 1'b0;
  int idle_levels [4] = '{0, 10, 30, 60};

  // Stimulus-side view of the fill level, used to aim positions and steer the fill.
  int list_len  = 0;
  int ops_sent  = 0;
  int show_cnt  = 0;
  int full_hits = 0;
  int cyc_cnt   = 0;

  positional_list_engine uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (op_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (op_item),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_item)
  );

  ple_checker u_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (op_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (op_item),
    .out_valid_i   (res_valid),
    .out_stall_i   (res_stall),
    .out_data_i    (res_item),
    .err_cnt_o     (err_cnt),
    .pend_cnt_o    (pend_cnt),
    .checked_cnt_o (checked_cnt)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: ends a hung run.
  initial begin
    while (cyc_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc_cnt++;
    end
    $display("tb_top: cycle limit reached, %0d results still owed", pend_cnt);
    $display("tb_top: done, errors");
    $finish;
  end

  // Result side: random stall bursts, none in the quiet tail.
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(99) < out_idle_pct) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      res_stall <= 1'b0;
    end
  end

  // Mostly random words, with the signed extremes mixed in.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // One operation transfer. Valid stays high into the next call unless an
  // idle gap is drawn, so valid is never lowered and raised in one step.
  task automatic send_op(input logic [FUNC_W-1:0] f, input int pos,
                         input logic [DATA_W-1:0] v);
    in_item_t it;
    bit       pos_ok;
    it.func     = f;
    it.position = POS_W'(pos);
    it.value    = v;
    op_valid <= 1'b1;
    op_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    ops_sent++;
    case (f)
      FN_INS_AT, FN_INS_START, FN_INS_END: begin
        pos_ok = (f != FN_INS_AT) || (pos >= 1 && pos <= list_len + 1);
        if (pos_ok && list_len == DEPTH) full_hits++;
        else if (pos_ok) list_len++;
      end
      FN_DEL_AT:                if (pos >= 1 && pos <= list_len) list_len--;
      FN_DEL_START, FN_DEL_END: if (list_len > 0) list_len--;
      FN_SHOW:                  show_cnt++;
      default: ;
    endcase

    if (!quiet && $urandom_range(99) < in_idle_pct) begin
      op_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  initial begin
    int               n;
    int               roll;
    int               pos;
    bit               growing;
    logic [FUNC_W-1:0] f;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: empty-list cases first.
    send_op(FN_SHOW,      0, '0);
    send_op(FN_DEL_START, 0, pick_value());
    send_op(FN_DEL_END,   0, pick_value());
    send_op(FN_DEL_AT,    1, pick_value());     // delete at on empty is a range error
    send_op(FN_INS_AT,    0, pick_value());     // position zero
    send_op(FN_INS_AT,    2, pick_value());     // beyond count + 1
    // Build a small list from every insert flavor, with extreme words.
    send_op(FN_INS_AT,    1, 32'h7fff_ffff);
    send_op(FN_INS_START, 0, 32'h8000_0000);
    send_op(FN_INS_END,   0, 32'hffff_ffff);
    send_op(FN_INS_AT,    2, '0);               // middle insert lands at position 2
    send_op(FN_UNUSED,   31, pick_value());
    send_op(FN_SHOW,      0, '0);
    send_op(FN_DEL_AT,    0, '0);
    send_op(FN_DEL_AT,    2, '0);               // middle delete
    // Fill to the top, alternating tail position and head.
    while (list_len < DEPTH) begin
      if (list_len % 2 == 0) send_op(FN_INS_AT, list_len + 1, $urandom());
      else send_op(FN_INS_START, 0, $urandom());
    end
    send_op(FN_INS_AT, DEPTH + 2, pick_value()); // range wins over full
    send_op(FN_INS_AT, DEPTH + 1, pick_value()); // valid position, list full
    send_op(FN_INS_START, 0, pick_value());
    send_op(FN_SHOW, 0, '0);                     // longest listing
    send_op(FN_DEL_AT, 31, '0);
    send_op(FN_DEL_END, 0, '0);

    // Random: alternate grow and shrink phases so the fill level sweeps
    // between empty and full; most positions are in range.
    growing = 1'b0;
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) begin
        in_idle_pct  = idle_levels[$urandom_range(3)];
        out_idle_pct = idle_levels[$urandom_range(3)];
      end
      if (n == RANDOM_OPS - QUIET_TAIL) quiet = 1'b1;
      if (list_len == DEPTH && $urandom_range(3) == 0) growing = 1'b0;
      if (list_len == 0 && $urandom_range(3) == 0) growing = 1'b1;
      if ($urandom_range(49) == 0) growing = !growing;

      roll = $urandom_range(99);
      pos  = $urandom_range(31);
      if (roll < 3) begin
        f = FN_UNUSED;
      end else if (roll < 11) begin
        f = FN_SHOW;
      end else if (roll < (growing ? 70 : 38)) begin
        case ($urandom_range(2))
          0:       f = FN_INS_AT;
          1:       f = FN_INS_START;
          default: f = FN_INS_END;
        endcase
        if ($urandom_range(99) < 85) pos = $urandom_range(1, list_len + 1);
      end else begin
        case ($urandom_range(2))
          0:       f = FN_DEL_AT;
          1:       f = FN_DEL_START;
          default: f = FN_DEL_END;
        endcase
        if (list_len > 0 && $urandom_range(99) < 85) pos = $urandom_range(1, list_len);
      end
      send_op(f, pos, pick_value());
    end
    op_valid <= 1'b0;

    // Let the checker register the last transfer, then drain.
    repeat (2) @(posedge clk);
    while (pend_cnt != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (pend_cnt != 0) $display("tb_top: %0d predicted results never arrived", pend_cnt);
    $display("tb_top: %0d operations sent (%0d shows, %0d inserts into a full list)",
             ops_sent, show_cnt, full_hits);
    $display("tb_top: %0d results compared, %0d failures", checked_cnt, err_cnt + pend_cnt);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
